// ----- rtl/modbus_rtu_measurand_master_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the measurand master
// Clocked, reset-gated property checks used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_MEASURAND_MASTER_ASSERT_SVH
`define MODBUS_RTU_MEASURAND_MASTER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define MRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define MRM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/mrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrm_pkg
// Beat types, protocol constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrm_pkg;

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_RX_BYTE = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    localparam logic [1:0] FRAME_OK    = 2'd0;
    localparam logic [1:0] FRAME_SHORT = 2'd1;
    localparam logic [1:0] FRAME_CRC   = 2'd2;

    localparam logic [1:0] REPORT_VALUE   = 2'd0;
    localparam logic [1:0] REPORT_INVALID = 2'd1;
    localparam logic [1:0] REPORT_EXCEPT  = 2'd2;
    localparam logic [1:0] REPORT_TIMEOUT = 2'd3;

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FUNC_READ_INPUT   = 8'h04;
    localparam logic [7:0]  FUNC_EXCEPTION    = 8'h80;
    localparam logic [15:0] REQ_REG_COUNT     = 16'd5;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h01;

    localparam logic [2:0] BEAT_LAST = 3'd7;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] reg_address;
        logic [7:0]  rx_byte;
        logic        frame_end;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_data;
        logic        tx_last;
        logic        frame_done;
        logic [1:0]  frame_status;
        logic        report_valid;
        logic [1:0]  report_status;
        logic [31:0] measurand_bits;
    } out_item_t;

    // Frame judgement handed from the receive path to the top level
    typedef struct packed {
        logic [1:0]  frame_status;
        logic        report_valid;
        logic [1:0]  report_status;
        logic [31:0] measurand_bits;
    } rx_result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/modbus_rtu_measurand_master.sv -----
`timescale 1ns / 1ps
// Pipeline: a command beat is registered in the work stage; its result beats are
//   registered in the output register, which holds while the output stalls.
// Throughput: one received byte or timeout per cycle unless the output stalls;
//   a request holds the work stage until its eight frame bytes are out, one per cycle.
// Reset: slave address 1, no read pending, receive CRC 0xFFFF, beat and valids 0.
// ----------------------------------------------------------------------------
// modbus_rtu_measurand_master
// Modbus RTU master issuing read-input-register requests and judging replies.
// ----------------------------------------------------------------------------
module modbus_rtu_measurand_master
    import mrm_pkg::*;
#(
    parameter int MAX_FRAME = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  in_item_t   cmd,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output out_item_t  rsp
);

    logic [7:0] slave_addr_reg;
    logic       s1_valid_reg, s1_valid_next;
    in_item_t   s1_reg;
    logic [2:0] beat_reg, beat_next;
    logic [15:0] tx_crc_reg, tx_crc_next;
    logic       pending_read_reg, pending_read_next;
    logic       rsp_valid_reg, rsp_valid_next;
    out_item_t  rsp_reg, rsp_next;

    logic       out_free;
    logic       is_req, is_rx, is_tmo;
    logic       has_out, s1_go, s1_done, cmd_take, rx_en;
    logic [7:0] tx_byte;
    rx_result_t rx_res;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign is_req   = s1_reg.mode == MODE_REQUEST;
    assign is_rx    = s1_reg.mode == MODE_RX_BYTE;
    assign is_tmo   = s1_reg.mode == MODE_TIMEOUT;

    assign has_out  = is_req || (is_rx && s1_reg.frame_end) || (is_tmo && pending_read_reg);
    assign s1_go    = s1_valid_reg && (!has_out || out_free);
    assign s1_done  = s1_go && (!is_req || beat_reg == BEAT_LAST);
    assign cmd_stall = s1_valid_reg && !s1_done;
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign rx_en     = s1_go && is_rx;

    mrm_rx_frame #(
        .MAX_FRAME (MAX_FRAME)
    ) u_rx (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (rx_en),
        .rx_byte      (s1_reg.rx_byte),
        .frame_end    (s1_reg.frame_end),
        .pending_read (pending_read_reg),
        .result       (rx_res)
    );

    always_comb
    begin
        unique case (beat_reg)
            3'd0:    tx_byte = slave_addr_reg;
            3'd1:    tx_byte = FUNC_READ_INPUT;
            3'd2:    tx_byte = s1_reg.reg_address[15:8];
            3'd3:    tx_byte = s1_reg.reg_address[7:0];
            3'd4:    tx_byte = REQ_REG_COUNT[15:8];
            3'd5:    tx_byte = REQ_REG_COUNT[7:0];
            3'd6:    tx_byte = tx_crc_reg[7:0];
            default: tx_byte = tx_crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        beat_next         = beat_reg;
        tx_crc_next       = tx_crc_reg;
        pending_read_next = pending_read_reg;
        s1_valid_next     = s1_valid_reg;
        rsp_valid_next    = rsp_valid_reg;
        rsp_next          = '0;

        if (is_req)
        begin
            rsp_next.tx_valid = 1'b1;
            rsp_next.tx_data  = tx_byte;
            rsp_next.tx_last  = beat_reg == BEAT_LAST;
        end
        else if (is_rx)
        begin
            rsp_next.frame_done     = 1'b1;
            rsp_next.frame_status   = rx_res.frame_status;
            rsp_next.report_valid   = rx_res.report_valid;
            rsp_next.report_status  = rx_res.report_status;
            rsp_next.measurand_bits = rx_res.measurand_bits;
        end
        else
        begin
            rsp_next.report_valid  = 1'b1;
            rsp_next.report_status = REPORT_TIMEOUT;
        end

        if (s1_go && is_req)
        begin
            beat_next = (beat_reg == BEAT_LAST) ? 3'd0 : beat_reg + 3'd1;
            // CRC of the header builds up as its bytes go out
            if (beat_reg == 3'd0)
            begin
                tx_crc_next       = crc_feed(CRC_INIT, tx_byte);
                pending_read_next = 1'b1;
            end
            else if (beat_reg < 3'd6)
            begin
                tx_crc_next = crc_feed(tx_crc_reg, tx_byte);
            end
        end
        else if (s1_go && is_rx && s1_reg.frame_end && rx_res.report_valid)
        begin
            pending_read_next = 1'b0;
        end
        else if (s1_go && is_tmo)
        begin
            pending_read_next = 1'b0;
        end

        if (s1_go && has_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg   <= SLAVE_ADDR_RESET;
            s1_valid_reg     <= 1'b0;
            beat_reg         <= 3'd0;
            pending_read_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                slave_addr_reg <= cfg_wdata;
            end
            s1_valid_reg     <= s1_valid_next;
            beat_reg         <= beat_next;
            pending_read_reg <= pending_read_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_reg <= cmd;
        end
        if (s1_go && has_out)
        begin
            rsp_reg <= rsp_next;
        end
        tx_crc_reg <= tx_crc_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "modbus_rtu_measurand_master_assert.svh"

    `MRM_ASSERT(a_last_while_pending, (rsp_valid_reg && rsp_reg.tx_last) |-> pending_read_reg, "request end beat without pending read")
    `MRM_ASSERT(a_report_clears, (s1_go && has_out && rsp_next.report_valid) |=> !pending_read_reg, "report left read pending")
    `MRM_ASSERT(a_beat_in_request, (beat_reg != 3'd0) |-> (s1_valid_reg && is_req), "beat count outside a request")
    `MRM_ASSERT_NEVER(a_stall_when_empty, !s1_valid_reg && cmd_stall, "command stalled with empty stage")

endmodule

// ----- rtl/mrm_rx_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrm_rx_frame
// Receive path: running CRC, fixed-position capture and frame judgement.
// ----------------------------------------------------------------------------
module mrm_rx_frame
    import mrm_pkg::*;
#(
    parameter int MAX_FRAME = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    input  logic       pending_read,
    output rx_result_t result
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic [CNT_W-1:0] rx_count_reg, rx_count_next, cnt_upd;
    logic [15:0]      running_crc_reg, running_crc_next, crc_upd;
    logic [15:0]      last_two_reg, last_two_next, ltb_upd;
    logic [7:0]       function_code_reg, function_code_next, fc_upd;
    logic [7:0]       byte_count_reg, byte_count_next, bc_upd;
    logic [47:0]      register_bytes_reg, register_bytes_next, rb_upd;

    logic             counting;
    logic [9:0]       len;
    logic [9:0]       need_len;
    logic [6:0]       regs;
    logic [15:0]      rcv_crc;

    assign counting = rx_count_reg < CNT_W'(MAX_FRAME);

    // State after taking this byte; bytes past the limit leave it untouched
    always_comb
    begin
        cnt_upd = rx_count_reg;
        crc_upd = running_crc_reg;
        ltb_upd = last_two_reg;
        fc_upd  = function_code_reg;
        bc_upd  = byte_count_reg;
        rb_upd  = register_bytes_reg;
        if (counting)
        begin
            cnt_upd = rx_count_reg + CNT_W'(1);
            if (rx_count_reg >= CNT_W'(2))
            begin
                crc_upd = crc_feed(running_crc_reg, last_two_reg[15:8]);
            end
            ltb_upd = {last_two_reg[7:0], rx_byte};
            if (rx_count_reg == CNT_W'(1))
            begin
                fc_upd = rx_byte;
            end
            else if (rx_count_reg == CNT_W'(2))
            begin
                bc_upd = rx_byte;
            end
            else if (rx_count_reg >= CNT_W'(3) && rx_count_reg <= CNT_W'(8))
            begin
                rb_upd = {register_bytes_reg[39:0], rx_byte};
            end
        end
    end

    assign len      = 10'(cnt_upd);
    assign regs     = bc_upd[7:1];
    assign need_len = {2'b00, regs, 1'b0} + 10'd5;
    assign rcv_crc  = {ltb_upd[7:0], ltb_upd[15:8]};

    always_comb
    begin
        result = '0;
        priority if (len < 10'd4)
        begin
            result.frame_status = FRAME_SHORT;
        end
        else if (rcv_crc != crc_upd)
        begin
            result.frame_status = FRAME_CRC;
        end
        else
        begin
            result.frame_status = FRAME_OK;
            if ((fc_upd & FUNC_EXCEPTION) != 8'h00)
            begin
                if (pending_read)
                begin
                    result.report_valid  = 1'b1;
                    result.report_status = REPORT_EXCEPT;
                end
            end
            else if ((fc_upd == FUNC_READ_HOLDING || fc_upd == FUNC_READ_INPUT)
                     && !(len < need_len) && pending_read)
            begin
                result.report_valid = 1'b1;
                if (regs >= 7'd3 && rb_upd[47:32] != 16'h0000)
                begin
                    result.report_status  = REPORT_VALUE;
                    result.measurand_bits = rb_upd[31:0];
                end
                else
                begin
                    result.report_status = REPORT_INVALID;
                end
            end
        end
    end

    always_comb
    begin
        rx_count_next       = rx_count_reg;
        running_crc_next    = running_crc_reg;
        last_two_next       = last_two_reg;
        function_code_next  = function_code_reg;
        byte_count_next     = byte_count_reg;
        register_bytes_next = register_bytes_reg;
        if (en)
        begin
            if (frame_end)
            begin
                rx_count_next       = '0;
                running_crc_next    = CRC_INIT;
                last_two_next       = '0;
                function_code_next  = '0;
                byte_count_next     = '0;
                register_bytes_next = '0;
            end
            else
            begin
                rx_count_next       = cnt_upd;
                running_crc_next    = crc_upd;
                last_two_next       = ltb_upd;
                function_code_next  = fc_upd;
                byte_count_next     = bc_upd;
                register_bytes_next = rb_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg       <= '0;
            running_crc_reg    <= CRC_INIT;
            last_two_reg       <= '0;
            function_code_reg  <= '0;
            byte_count_reg     <= '0;
            register_bytes_reg <= '0;
        end
        else
        begin
            rx_count_reg       <= rx_count_next;
            running_crc_reg    <= running_crc_next;
            last_two_reg       <= last_two_next;
            function_code_reg  <= function_code_next;
            byte_count_reg     <= byte_count_next;
            register_bytes_reg <= register_bytes_next;
        end
    end

endmodule
